[hw/rtl/conv2d_pkg.sv]
package conv2d_pkg;

  // Store geometry.
  localparam int MaxRows     = 64;
  localparam int MaxCols     = 64;
  localparam int MaxKernel   = 7;
  localparam int SampleWidth = 16;

  // Field and register widths.
  localparam int IdxW      = 6;
  localparam int DimW      = 7;
  localparam int KerW      = 3;
  localparam int PadW      = 2;
  localparam int StepW     = 3;
  localparam int TypeW     = 2;
  localparam int AccW      = 40;
  localparam int ProdW     = 2 * SampleWidth;
  localparam int RowAddrW  = $clog2(MaxRows);
  localparam int ColAddrW  = $clog2(MaxCols);
  localparam int ImgAddrW  = RowAddrW + ColAddrW;
  localparam int KerAddrW  = $clog2(MaxKernel * MaxKernel);
  localparam int ImgDepth  = MaxRows * MaxCols;
  localparam int KerDepth  = MaxKernel * MaxKernel;
  // Window coordinates in the padded image: row * step + tap.
  localparam int CoordW    = 9;

  // APB port.
  localparam int PAddrW = 5;
  localparam int PDataW = 32;

  // Register indexes.
  localparam logic [2:0] RegImageRows  = 3'd0;
  localparam logic [2:0] RegImageCols  = 3'd1;
  localparam logic [2:0] RegKernelSize = 3'd2;
  localparam logic [2:0] RegPadWidth   = 3'd3;
  localparam logic [2:0] RegStepSize   = 3'd4;

  // Reset values of the registers.
  localparam logic [DimW-1:0]  ResetRows = DimW'(8);
  localparam logic [DimW-1:0]  ResetCols = DimW'(8);
  localparam logic [KerW-1:0]  ResetKer  = KerW'(3);
  localparam logic [PadW-1:0]  ResetPad  = PadW'(0);
  localparam logic [StepW-1:0] ResetStep = StepW'(1);

  // Request codes.
  typedef enum logic [TypeW-1:0] {
    ReqKernelWr = 2'd0,
    ReqImageWr  = 2'd1,
    ReqRead     = 2'd2
  } req_type_e;

endpackage

[hw/rtl/conv2d_req_if.sv]
interface conv2d_req_if import conv2d_pkg::*; ();
  logic                           valid;
  logic                           ready;
  logic        [TypeW-1:0]        req_type;
  logic        [IdxW-1:0]         row_index;
  logic        [IdxW-1:0]         col_index;
  logic signed [SampleWidth-1:0]  sample;

  modport source (output valid, req_type, row_index, col_index, sample, input ready);
  modport sink   (input valid, req_type, row_index, col_index, sample, output ready);
endinterface

[hw/rtl/conv2d_rsp_if.sv]
interface conv2d_rsp_if import conv2d_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [AccW-1:0]  conv_value;
  logic                    in_range;

  modport source (output valid, conv_value, in_range, input ready);
  modport sink   (input valid, conv_value, in_range, output ready);
endinterface

[hw/rtl/conv2d_padded_strided.sv]
// Writes of a kernel weight or an image sample are accepted every cycle while no read is in progress.
// A read inside the output steps through setup, the window check, one multiply-accumulate per tap
// (K*K taps, K: clamped kernel side) through a three-stage memory/multiply pipe, and a drain.
// A read outside the output goes from the window check straight to the result. A read blocks new
// requests until its result is loaded into the result register, which waits for the previous result to leave.
// Asynchronous reset restores the register defaults; the stores hold unknown data until written.
module conv2d_padded_strided import conv2d_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  conv2d_req_if.sink         req_i,
  conv2d_rsp_if.source       rsp_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PAddrW-1:0]  paddr,
  input  logic [PDataW-1:0]  pwdata,
  output logic [PDataW-1:0]  prdata,
  output logic               pready
);

  typedef enum logic [2:0] {
    StIdle,
    StSetup,
    StCheck,
    StMac,
    StDrain,
    StFinish
  } state_e;

  // Configuration registers.
  logic [DimW-1:0]  image_rows_q, image_cols_q;
  logic [KerW-1:0]  ker_side_q;
  logic [PadW-1:0]  pad_width_q;
  logic [StepW-1:0] step_size_q;

  logic       cfg_wr;
  logic [2:0] cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = paddr[4:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      image_rows_q  <= ResetRows;
      image_cols_q  <= ResetCols;
      ker_side_q    <= ResetKer;
      pad_width_q   <= ResetPad;
      step_size_q   <= ResetStep;
    end else if (cfg_wr) begin
      case (cfg_idx)
        RegImageRows:  image_rows_q  <= pwdata[DimW-1:0];
        RegImageCols:  image_cols_q  <= pwdata[DimW-1:0];
        RegKernelSize: ker_side_q    <= pwdata[KerW-1:0];
        RegPadWidth:   pad_width_q   <= pwdata[PadW-1:0];
        RegStepSize:   step_size_q   <= pwdata[StepW-1:0];
        default: ;
      endcase
    end
  end

  // Register read-back.
  always_comb begin
    case (cfg_idx)
      RegImageRows:  prdata = PDataW'(image_rows_q);
      RegImageCols:  prdata = PDataW'(image_cols_q);
      RegKernelSize: prdata = PDataW'(ker_side_q);
      RegPadWidth:   prdata = PDataW'(pad_width_q);
      RegStepSize:   prdata = PDataW'(step_size_q);
      default:       prdata = '0;
    endcase
  end

  // Effective geometry after clamping out-of-range register values.
  logic [DimW-1:0]   rows_eff, cols_eff;
  logic [KerW-1:0]   k_eff;
  logic [StepW-1:0]  s_eff;
  logic [CoordW-1:0] pad_c, span_rows, span_cols;

  always_comb begin
    if (image_rows_q == '0) begin
      rows_eff = DimW'(1);
    end else if (image_rows_q > DimW'(MaxRows)) begin
      rows_eff = DimW'(MaxRows);
    end else begin
      rows_eff = image_rows_q;
    end
    if (image_cols_q == '0) begin
      cols_eff = DimW'(1);
    end else if (image_cols_q > DimW'(MaxCols)) begin
      cols_eff = DimW'(MaxCols);
    end else begin
      cols_eff = image_cols_q;
    end
    if (ker_side_q == '0) begin
      k_eff = KerW'(1);
    end else if (ker_side_q > KerW'(MaxKernel)) begin
      k_eff = KerW'(MaxKernel);
    end else begin
      k_eff = ker_side_q;
    end
    s_eff     = (step_size_q == '0) ? StepW'(1) : step_size_q;
    pad_c     = CoordW'(pad_width_q);
    span_rows = CoordW'(rows_eff) + (pad_c << 1);
    span_cols = CoordW'(cols_eff) + (pad_c << 1);
  end

  // Sequencer state.
  state_e            state_q;
  logic [IdxW-1:0]   row_q, col_q;
  logic [CoordW-1:0] base_r_q, base_c_q;
  logic [KerW-1:0]   a_q, b_q;
  logic              fire1_q, fire2_q, last1_q, last2_q, ok1_q, ok2_q;
  logic [AccW-1:0]   acc_q;
  logic              inr_q;
  logic              rsp_valid_q;
  logic [AccW-1:0]   rsp_value_q;
  logic              rsp_inr_q;
  logic              rsp_load;

  logic req_acc, img_wr, ker_wr;
  assign req_i.ready = (state_q == StIdle);
  assign req_acc     = req_i.valid && req_i.ready;
  assign img_wr      = req_acc && (req_i.req_type == ReqImageWr);
  assign ker_wr      = req_acc && (req_i.req_type == ReqKernelWr) &&
                       (req_i.row_index < IdxW'(MaxKernel)) &&
                       (req_i.col_index < IdxW'(MaxKernel));

  // The result register takes a new value once the previous one has left.
  assign rsp_load    = (state_q == StFinish) && (!rsp_valid_q || rsp_o.ready);

  // Tap address generation: padded coordinates and the border test.
  logic [CoordW-1:0]   pr, pc, ir, ic;
  logic                tap_ok, last_tap, in_out;
  logic [ImgAddrW-1:0] img_raddr;
  logic [KerAddrW-1:0] ker_raddr, ker_waddr;

  always_comb begin
    pr        = base_r_q + CoordW'(a_q);
    pc        = base_c_q + CoordW'(b_q);
    ir        = pr - pad_c;
    ic        = pc - pad_c;
    tap_ok    = (pr >= pad_c) && (ir < CoordW'(rows_eff)) &&
                (pc >= pad_c) && (ic < CoordW'(cols_eff));
    img_raddr = {ir[RowAddrW-1:0], ic[ColAddrW-1:0]};
    ker_raddr = KerAddrW'(a_q) * KerAddrW'(MaxKernel) + KerAddrW'(b_q);
    ker_waddr = KerAddrW'(req_i.row_index) * KerAddrW'(MaxKernel) +
                KerAddrW'(req_i.col_index);
    last_tap  = (a_q == k_eff - KerW'(1)) && (b_q == k_eff - KerW'(1));
    // The window fits when row * step + k does not pass the padded span.
    in_out    = (base_r_q + CoordW'(k_eff) <= span_rows) &&
                (base_c_q + CoordW'(k_eff) <= span_cols);
  end

  // Sample and weight stores.
  logic signed [SampleWidth-1:0] img_mem [ImgDepth];
  logic signed [SampleWidth-1:0] ker_mem [KerDepth];
  logic signed [SampleWidth-1:0] img_rd_q, ker_rd_q;

  always_ff @(posedge clk_i) begin
    if (img_wr) begin
      img_mem[{req_i.row_index[RowAddrW-1:0], req_i.col_index[ColAddrW-1:0]}] <= req_i.sample;
    end
    img_rd_q <= img_mem[img_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (ker_wr) begin
      ker_mem[ker_waddr] <= req_i.sample;
    end
    ker_rd_q <= ker_mem[ker_raddr];
  end

  // Shared multiplier with a registered product.
  logic signed [ProdW-1:0] prod_q;

  always_ff @(posedge clk_i) begin
    prod_q <= img_rd_q * ker_rd_q;
  end

  // Sequencer, tap pipe control, accumulator and result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      row_q       <= '0;
      col_q       <= '0;
      base_r_q    <= '0;
      base_c_q    <= '0;
      a_q         <= '0;
      b_q         <= '0;
      fire1_q     <= 1'b0;
      fire2_q     <= 1'b0;
      last1_q     <= 1'b0;
      last2_q     <= 1'b0;
      ok1_q       <= 1'b0;
      ok2_q       <= 1'b0;
      acc_q       <= '0;
      inr_q       <= 1'b0;
      rsp_valid_q <= 1'b0;
      rsp_value_q <= '0;
      rsp_inr_q   <= 1'b0;
    end else begin
      // Pipe stages follow the tap issue of the previous cycles.
      fire1_q <= (state_q == StMac);
      last1_q <= (state_q == StMac) && last_tap;
      ok1_q   <= tap_ok;
      fire2_q <= fire1_q;
      last2_q <= last1_q;
      ok2_q   <= ok1_q;

      // The result stays valid until its transaction completes.
      if (rsp_load) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp_valid_q && rsp_o.ready) begin
        rsp_valid_q <= 1'b0;
      end

      case (state_q)
        StIdle: begin
          if (req_acc && (req_i.req_type == ReqRead)) begin
            row_q   <= req_i.row_index;
            col_q   <= req_i.col_index;
            state_q <= StSetup;
          end
        end
        StSetup: begin
          base_r_q <= CoordW'(row_q) * CoordW'(s_eff);
          base_c_q <= CoordW'(col_q) * CoordW'(s_eff);
          state_q  <= StCheck;
        end
        StCheck: begin
          a_q   <= '0;
          b_q   <= '0;
          inr_q <= in_out;
          if (in_out) begin
            state_q <= StMac;
          end else begin
            state_q <= StFinish;
          end
        end
        StMac: begin
          if (b_q == k_eff - KerW'(1)) begin
            b_q <= '0;
            a_q <= a_q + KerW'(1);
          end else begin
            b_q <= b_q + KerW'(1);
          end
          if (last_tap) begin
            state_q <= StDrain;
          end
        end
        StDrain: begin
          if (last2_q) begin
            state_q <= StFinish;
          end
        end
        StFinish: begin
          // Load the result once the previous one has left.
          if (rsp_load) begin
            rsp_value_q <= acc_q;
            rsp_inr_q   <= inr_q;
            state_q     <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase

      // Clear the sum before a read, then add the products of taps inside the image.
      if (state_q == StCheck) begin
        acc_q <= '0;
      end else if (fire2_q && ok2_q) begin
        acc_q <= acc_q + AccW'(prod_q);
      end
    end
  end

  assign rsp_o.valid      = rsp_valid_q;
  assign rsp_o.conv_value = rsp_value_q;
  assign rsp_o.in_range   = rsp_inr_q;

endmodule
